/* hdl/orac_pkg.sv */
// ---------------------------------------------------------------------------
// orac_pkg: shared types and codes of the object range access classifier
// Command and result items, configuration image, object table entry,
// compare unit flags and sequencer states.
// ---------------------------------------------------------------------------
package orac_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_INSERT   = 2'd1,
        OP_CLASSIFY = 2'd2
    } t_op;

    // Status codes of a result item
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_CAPACITY = 2'd2,
        STAT_OVERFLOW = 2'd3
    } t_status;

    // Range classes of a classify result
    typedef enum logic [2:0] {
        CLS_WITHIN         = 3'd0,
        CLS_WITHIN_OTHER   = 3'd1,
        CLS_GAP            = 3'd2,
        CLS_STARTS_IN      = 3'd3,
        CLS_ENDS_IN        = 3'd4,
        CLS_SPANS          = 3'd5,
        CLS_OUTSIDE_REGION = 3'd6,
        CLS_CONST_OVERLAP  = 3'd7
    } t_access_class;

    // Configuration register indexes
    localparam logic [2:0] CFG_REGION_ZERO  = 3'd0;
    localparam logic [2:0] CFG_REGION_ONE   = 3'd1;
    localparam logic [2:0] CFG_REGION_TWO   = 3'd2;
    localparam logic [2:0] CFG_REGION_THREE = 3'd3;
    localparam logic [2:0] CFG_CONST_SELECT = 3'd4;

    // Region index reported when no region holds the access
    localparam logic [2:0] NO_REGION = 3'd4;

    typedef struct packed {
        t_op         op;
        logic [31:0] address;
        logic [31:0] size;
        logic        write_access;
        logic        intended_valid;
        logic [5:0]  intended_entry;
    } t_cmd;

    typedef struct packed {
        t_status       status;
        t_access_class access_class;
        logic [31:0]   last_address;
        logic [2:0]    region_index;
        logic          start_found;
        logic [5:0]    start_entry;
        logic          end_found;
        logic [5:0]    end_entry;
        logic          contain_found;
        logic [5:0]    contain_entry;
        logic [6:0]    object_count;
    } t_result;

    // Region bounds: bits 31..0 base, bits 63..32 exclusive limit
    typedef struct packed {
        logic [3:0][63:0] bounds;
        logic [1:0]       const_sel;
    } t_cfg;

    // One stored object: base and inclusive last byte
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] last;
    } t_obj;

    // Object table write request
    typedef struct packed {
        logic en;
        t_obj data;
    } t_obj_wr;

    // Flags of the shared compare unit
    typedef struct packed {
        logic a_ge_lo;
        logic a_lt_hi;
        logic a_le_hi;
        logic e_ge_lo;
        logic e_lt_hi;
        logic e_le_hi;
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_REGION,
        ST_CONST,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

/* hdl/orac_mem.sv */
// ---------------------------------------------------------------------------
// orac_mem: object table storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module orac_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  orac_pkg::t_obj_wr i_wr,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [IDX_W-1:0] i_raddr,
    output orac_pkg::t_obj   o_rdata
);
    import orac_pkg::*;

    t_obj r_mem [DEPTH];
    t_obj r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    // Read one entry; the read data is registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/orac_cmp.sv */
// ---------------------------------------------------------------------------
// orac_cmp: shared range compare unit
// Compares the access start and last byte against one low/high pair.
// ---------------------------------------------------------------------------
module orac_cmp (
    input  logic [31:0]   i_addr,
    input  logic [31:0]   i_end,
    input  logic [31:0]   i_lo,
    input  logic [31:0]   i_hi,
    output orac_pkg::t_cmp o_cmp
);
    import orac_pkg::*;

    logic a_lt_hi;
    logic e_lt_hi;

    assign a_lt_hi = (i_addr < i_hi);
    assign e_lt_hi = (i_end < i_hi);

    // Start and last byte against both bounds
    always_comb begin
        o_cmp.a_ge_lo = (i_addr >= i_lo);
        o_cmp.a_lt_hi = a_lt_hi;
        o_cmp.a_le_hi = a_lt_hi | (i_addr == i_hi);
        o_cmp.e_ge_lo = (i_end >= i_lo);
        o_cmp.e_lt_hi = e_lt_hi;
        o_cmp.e_le_hi = e_lt_hi | (i_end == i_hi);
    end

endmodule

/* hdl/orac_core.sv */
// ---------------------------------------------------------------------------
// orac_core: sequencer of the classifier
// Computes the last byte, walks the regions and the object table through
// one shared compare unit, and builds the result item.
// ---------------------------------------------------------------------------
module orac_core #(
    parameter int MAX_OBJECTS  = 64,
    parameter int REGION_COUNT = 4,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  orac_pkg::t_cmd    i_cmd,
    input  orac_pkg::t_cfg    i_cfg,
    output logic              o_busy,
    output orac_pkg::t_obj_wr o_mem_wr,
    output logic [IDX_W-1:0]  o_mem_waddr,
    output logic [IDX_W-1:0]  o_mem_raddr,
    input  orac_pkg::t_obj    i_mem_rdata,
    output logic              o_valid,
    output orac_pkg::t_result o_result
);
    import orac_pkg::*;

    localparam logic [1:0]       LAST_REGION = 2'(REGION_COUNT - 1);
    localparam logic [2:0]       REGIONS_USED = 3'(REGION_COUNT);
    localparam logic [CNT_W-1:0] FULL_COUNT   = CNT_W'(MAX_OBJECTS);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [31:0]      r_end, n_end;
    logic [1:0]       r_ri, n_ri;
    logic [2:0]       r_region, n_region;
    logic             r_const, n_const;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic             r_s_f, n_s_f;
    logic [IDX_W-1:0] r_s_i, n_s_i;
    logic             r_e_f, n_e_f;
    logic [IDX_W-1:0] r_e_i, n_e_i;
    logic             r_c_f, n_c_f;
    logic [IDX_W-1:0] r_c_i, n_c_i;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;
    logic             r_valid, n_valid;
    t_result          r_result, n_result;

    logic [31:0] delta;
    logic [32:0] sum;
    logic        ovf;
    logic        size_zero;
    logic [1:0]  sel_idx;
    logic [31:0] cmp_lo;
    logic [31:0] cmp_hi;
    t_cmp        cmp;
    logic        region_hit;
    logic        const_active;
    logic        hit_start;
    logic        hit_end;
    logic        hit_cont;
    logic        report;
    logic        show_cont;

    // Last byte of the held item and its overflow
    assign delta     = r_cmd.size - 32'd1;
    assign sum       = {1'b0, r_cmd.address} + {1'b0, delta};
    assign ovf       = sum[32];
    assign size_zero = (r_cmd.size == 32'd0);

    // Pick the operands of the compare unit
    always_comb begin
        sel_idx = (r_state == ST_CONST) ? i_cfg.const_sel : r_ri;
        if (r_state == ST_SCAN) begin
            cmp_lo = i_mem_rdata.base;
            cmp_hi = i_mem_rdata.last;
        end else begin
            cmp_lo = i_cfg.bounds[sel_idx][31:0];
            cmp_hi = i_cfg.bounds[sel_idx][63:32];
        end
    end

    orac_cmp u_cmp (
        .i_addr (r_cmd.address),
        .i_end  (r_end),
        .i_lo   (cmp_lo),
        .i_hi   (cmp_hi),
        .o_cmp  (cmp)
    );

    assign region_hit   = cmp.a_ge_lo & cmp.e_lt_hi;
    assign const_active = r_cmd.write_access & ({1'b0, i_cfg.const_sel} < REGIONS_USED);
    assign hit_start    = cmp.a_ge_lo & cmp.a_le_hi;
    assign hit_end      = cmp.e_ge_lo & cmp.e_le_hi;
    assign hit_cont     = cmp.a_ge_lo & cmp.e_le_hi;
    assign report       = (r_cmd.op == OP_CLASSIFY) & (r_status == STAT_OK);
    assign show_cont    = report & (r_region != NO_REGION) & !r_const & r_c_f;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_cmd.op == OP_CLASSIFY && !size_zero && !ovf) begin
                    n_state = ST_REGION;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_REGION: begin
                if (region_hit) begin
                    n_state = ST_CONST;
                end else if (r_ri == LAST_REGION) begin
                    n_state = ST_SCAN;
                end
            end
            ST_CONST: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_ptr >= r_count && !r_pend) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and result per state
    always_comb begin
        n_cmd    = r_cmd;
        n_end    = r_end;
        n_ri     = r_ri;
        n_region = r_region;
        n_const  = r_const;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_s_f    = r_s_f;
        n_s_i    = r_s_i;
        n_e_f    = r_e_f;
        n_e_i    = r_e_i;
        n_c_f    = r_c_f;
        n_c_i    = r_c_i;
        n_count  = r_count;
        n_status = r_status;
        n_valid  = 1'b0;
        n_result = r_result;
        o_mem_wr.en   = 1'b0;
        o_mem_wr.data = '{base: r_cmd.address, last: sum[31:0]};

        case (r_state)
            ST_IDLE: begin
                if (i_start) n_cmd = i_cmd;
            end
            ST_CALC: begin
                // Clear per-item state, then run the op
                n_status = STAT_OK;
                n_end    = 32'd0;
                n_region = NO_REGION;
                n_const  = 1'b0;
                n_ri     = 2'd0;
                n_ptr    = '0;
                n_pend   = 1'b0;
                n_s_f    = 1'b0;
                n_e_f    = 1'b0;
                n_c_f    = 1'b0;
                case (r_cmd.op)
                    OP_CLEAR: n_count = '0;
                    OP_INSERT: begin
                        if (!size_zero) begin
                            if (r_count >= FULL_COUNT) begin
                                n_status = STAT_CAPACITY;
                            end else if (ovf) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                o_mem_wr.en = 1'b1;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                    end
                    OP_CLASSIFY: begin
                        if (size_zero) begin
                            n_status = STAT_INVALID;
                        end else if (ovf) begin
                            n_status = STAT_OVERFLOW;
                        end else begin
                            n_end = sum[31:0];
                        end
                    end
                    default: n_status = STAT_INVALID;
                endcase
            end
            ST_REGION: begin
                // Take the first region that holds the whole access
                if (region_hit) begin
                    n_region = {1'b0, r_ri};
                end else begin
                    n_ri = r_ri + 2'd1;
                end
            end
            ST_CONST: begin
                if (const_active && cmp.a_lt_hi && cmp.e_ge_lo) n_const = 1'b1;
            end
            ST_SCAN: begin
                // Issue the next table read
                if (r_ptr < r_count) begin
                    n_ptr  = r_ptr + CNT_W'(1);
                    n_pend = 1'b1;
                    n_pidx = r_ptr[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                // Keep the first hit of each lookup
                if (r_pend) begin
                    if (!r_s_f && hit_start) begin
                        n_s_f = 1'b1;
                        n_s_i = r_pidx;
                    end
                    if (!r_e_f && hit_end) begin
                        n_e_f = 1'b1;
                        n_e_i = r_pidx;
                    end
                    if (!r_c_f && hit_cont) begin
                        n_c_f = 1'b1;
                        n_c_i = r_pidx;
                    end
                end
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_result.status        = r_status;
                n_result.last_address  = r_end;
                n_result.region_index  = r_region;
                n_result.start_found   = report & r_s_f;
                n_result.start_entry   = (report & r_s_f) ? 6'(r_s_i) : 6'd0;
                n_result.end_found     = report & r_e_f;
                n_result.end_entry     = (report & r_e_f) ? 6'(r_e_i) : 6'd0;
                n_result.contain_found = show_cont;
                n_result.contain_entry = show_cont ? 6'(r_c_i) : 6'd0;
                n_result.object_count  = 7'(r_count);
                // Grade the access
                if (!report) begin
                    n_result.access_class = CLS_WITHIN;
                end else if (r_region == NO_REGION) begin
                    n_result.access_class = CLS_OUTSIDE_REGION;
                end else if (r_const) begin
                    n_result.access_class = CLS_CONST_OVERLAP;
                end else if (r_c_f) begin
                    if (r_cmd.intended_valid &&
                        32'(r_c_i) != 32'(r_cmd.intended_entry)) begin
                        n_result.access_class = CLS_WITHIN_OTHER;
                    end else begin
                        n_result.access_class = CLS_WITHIN;
                    end
                end else if (r_s_f && r_e_f && r_s_i != r_e_i) begin
                    n_result.access_class = CLS_SPANS;
                end else if (r_s_f) begin
                    n_result.access_class = CLS_STARTS_IN;
                end else if (r_e_f) begin
                    n_result.access_class = CLS_ENDS_IN;
                end else begin
                    n_result.access_class = CLS_GAP;
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_end    <= n_end;
        r_ri     <= n_ri;
        r_region <= n_region;
        r_const  <= n_const;
        r_ptr    <= n_ptr;
        r_pidx   <= n_pidx;
        r_s_f    <= n_s_f;
        r_s_i    <= n_s_i;
        r_e_f    <= n_e_f;
        r_e_i    <= n_e_i;
        r_c_f    <= n_c_f;
        r_c_i    <= n_c_i;
        r_status <= n_status;
        r_result <= n_result;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_mem_waddr = r_count[IDX_W-1:0];
    assign o_mem_raddr = r_ptr[IDX_W-1:0];
    assign o_valid     = r_valid;
    assign o_result    = r_result;

endmodule

/* hdl/object_range_access_classifier.sv */
// ---------------------------------------------------------------------------
// object_range_access_classifier: top level
// Clear and insert: CALC, then DONE, which registers the result strobe.
// Classify: CALC, then one REGION step per region tried, CONST when a
//   region holds the access, then SCAN over the N stored objects and DONE.
// One item at a time; busy is low again in the cycle the result shows.
// Synchronous reset empties the table and zeroes the config registers.
// ---------------------------------------------------------------------------
module object_range_access_classifier #(
    parameter int MAX_OBJECTS  = 64,
    parameter int REGION_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  orac_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output orac_pkg::t_result o_result,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import orac_pkg::*;

    localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

    t_cfg             r_cfg;
    t_obj_wr          mem_wr;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_obj             mem_rdata;
    logic             core_busy;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_REGION_ZERO:  r_cfg.bounds[0] <= i_cfg_data;
                CFG_REGION_ONE:   r_cfg.bounds[1] <= i_cfg_data;
                CFG_REGION_TWO:   r_cfg.bounds[2] <= i_cfg_data;
                CFG_REGION_THREE: r_cfg.bounds[3] <= i_cfg_data;
                CFG_CONST_SELECT: r_cfg.const_sel <= i_cfg_data[1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    orac_mem #(
        .DEPTH (MAX_OBJECTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_waddr (mem_waddr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    orac_core #(
        .MAX_OBJECTS  (MAX_OBJECTS),
        .REGION_COUNT (REGION_COUNT),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start & !core_busy),
        .i_cmd       (i_cmd),
        .i_cfg       (r_cfg),
        .o_busy      (core_busy),
        .o_mem_wr    (mem_wr),
        .o_mem_waddr (mem_waddr),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    assign busy = core_busy;

endmodule
